[design/ogru_pkg.sv]
// Shared types and constants for the occupancy grid ray update block.
`timescale 1ns / 1ps

package ogru_pkg;

  localparam int CELL_W  = 18;  // signed cell coordinate
  localparam int DIFF_W  = 19;  // signed coordinate difference
  localparam int ERR_W   = 21;  // signed line error term
  localparam int SCORE_W = 7;
  localparam int COUNT_W = 10;

  localparam logic [SCORE_W-1:0] SCORE_UNKNOWN = 7'd50;
  localparam logic [SCORE_W-1:0] SCORE_MAX     = 7'd100;
  localparam logic [7:0]         SCORE_REPORT_UNKNOWN = 8'hFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX     = 10'd1023;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] REG_SCALE     = 3'd2;
  localparam logic [2:0] REG_FREE_STEP = 3'd3;
  localparam logic [2:0] REG_HIT_STEP  = 3'd4;

  // Operand selection for the shared coordinate converter.
  localparam logic [1:0] CONV_HIT_X    = 2'd0;
  localparam logic [1:0] CONV_HIT_Y    = 2'd1;
  localparam logic [1:0] CONV_SENSOR_X = 2'd2;
  localparam logic [1:0] CONV_SENSOR_Y = 2'd3;

  typedef struct packed {
    logic       clear_en;
    logic       load_in;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       order_en;
    logic       prep_en;
    logic       walk_en;
    logic       read_issue;
    logic       read_done;
    logic       hit_rd;
    logic       hit_wr;
    logic       out_load;
  } ogru_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic walk_last;
    logic out_free;
  } ogru_status_t;

endpackage

[design/ogru_ctrl.sv]
// Sequencing state machine for the occupancy grid ray update block.
`timescale 1ns / 1ps

module ogru_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_opcode,
  output logic                   in_ready,
  input  ogru_pkg::ogru_status_t stat,
  output ogru_pkg::ogru_cmd_t    cmd
);

  typedef enum logic [11:0] {
    ST_CLEAR     = 12'b000000000001,
    ST_IDLE      = 12'b000000000010,
    ST_READ      = 12'b000000000100,
    ST_READ_DATA = 12'b000000001000,
    ST_CONV      = 12'b000000010000,
    ST_ROUND     = 12'b000000100000,
    ST_ORDER     = 12'b000001000000,
    ST_PREP      = 12'b000010000000,
    ST_WALK      = 12'b000100000000,
    ST_HIT_RD    = 12'b001000000000,
    ST_HIT_WR    = 12'b010000000000,
    ST_DONE      = 12'b100000000000
  } state_t;

  state_t     state, state_next;
  logic [1:0] conv_idx, conv_idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      conv_idx <= 2'd0;
    end else begin
      state    <= state_next;
      conv_idx <= conv_idx_next;
    end
  end

  always_comb begin
    state_next    = state;
    conv_idx_next = conv_idx;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in   = 1'b1;
          conv_idx_next = 2'd0;
          state_next    = (in_opcode == ogru_pkg::OP_READ) ? ST_READ : ST_CONV;
        end
      end
      ST_READ: begin
        cmd.read_issue = 1'b1;
        state_next     = ST_READ_DATA;
      end
      ST_READ_DATA: begin
        cmd.read_done = 1'b1;
        state_next    = ST_DONE;
      end
      ST_CONV: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = conv_idx;
        conv_idx_next = conv_idx + 2'd1;
        if (conv_idx == ogru_pkg::CONV_SENSOR_Y) state_next = ST_ROUND;
      end
      ST_ROUND: state_next = ST_ORDER;
      ST_ORDER: begin
        cmd.order_en = 1'b1;
        state_next   = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep_en = 1'b1;
        state_next  = ST_WALK;
      end
      ST_WALK: begin
        cmd.walk_en = 1'b1;
        if (stat.walk_last) state_next = ST_HIT_RD;
      end
      ST_HIT_RD: begin
        cmd.hit_rd = 1'b1;
        state_next = ST_HIT_WR;
      end
      ST_HIT_WR: begin
        cmd.hit_wr = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule

[design/ogru_datapath.sv]
// Datapath: registers, coordinate converter, line walker and the score memory.
`timescale 1ns / 1ps

module ogru_datapath #(
  parameter int MAP_WIDTH  = 256,
  parameter int MAP_HEIGHT = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ogru_pkg::ogru_cmd_t    cmd,
  output ogru_pkg::ogru_status_t stat,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [15:0]            cfg_data,
  input  logic [15:0]            in_point_x_mm,
  input  logic [15:0]            in_point_y_mm,
  input  logic [15:0]            in_cell_address,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [15:0]            hit_address,
  output logic [7:0]             cell_score,
  output logic [9:0]             free_cells_updated,
  output logic                   out_of_map
);

  localparam int CELLS = MAP_WIDTH * MAP_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = ogru_pkg::CELL_W;
  localparam int DW    = ogru_pkg::DIFF_W;
  localparam int EW    = ogru_pkg::ERR_W;
  localparam int SW    = ogru_pkg::SCORE_W;

  // Configuration registers.
  logic signed [15:0] origin_x_mm, origin_y_mm;
  logic [15:0]        cells_per_mm_q16;
  logic [SW-1:0]      free_step, hit_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x_mm      <= 16'sd0;
      origin_y_mm      <= -16'sd10000;
      cells_per_mm_q16 <= 16'd1638;
      free_step        <= 7'd1;
      hit_step         <= 7'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        ogru_pkg::REG_ORIGIN_X:  origin_x_mm      <= cfg_data;
        ogru_pkg::REG_ORIGIN_Y:  origin_y_mm      <= cfg_data;
        ogru_pkg::REG_SCALE:     cells_per_mm_q16 <= cfg_data;
        ogru_pkg::REG_FREE_STEP: free_step        <= cfg_data[SW-1:0];
        ogru_pkg::REG_HIT_STEP:  hit_step         <= cfg_data[SW-1:0];
        default: ;
      endcase
    end
  end

  // Captured input item.
  logic signed [15:0] pt_x, pt_y;
  logic [15:0]        rd_cell;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      pt_x    <= in_point_x_mm;
      pt_y    <= in_point_y_mm;
      rd_cell <= in_cell_address;
    end
  end

  // Shared converter: one multiply per cycle, rounding in the cycle after.
  logic signed [15:0] coord_sel, origin_sel;
  logic signed [16:0] diff;
  logic signed [33:0] prod;
  logic [1:0]         prod_idx;
  logic               prod_valid;
  logic [33:0]        prod_mag, prod_rnd;
  logic signed [CW-1:0] round_cell;

  always_comb begin
    case (cmd.mul_sel)
      ogru_pkg::CONV_HIT_X:    begin coord_sel = pt_x;  origin_sel = origin_x_mm; end
      ogru_pkg::CONV_HIT_Y:    begin coord_sel = pt_y;  origin_sel = origin_y_mm; end
      ogru_pkg::CONV_SENSOR_X: begin coord_sel = 16'sd0; origin_sel = origin_x_mm; end
      default:                 begin coord_sel = 16'sd0; origin_sel = origin_y_mm; end
    endcase
    diff = 17'(coord_sel) - 17'(origin_sel);
  end

  always_ff @(posedge clk) begin
    if (rst) prod_valid <= 1'b0;
    else     prod_valid <= cmd.mul_en;
    if (cmd.mul_en) begin
      prod     <= 34'(diff) * $signed({18'd0, cells_per_mm_q16});
      prod_idx <= cmd.mul_sel;
    end
  end

  always_comb begin
    prod_mag   = prod[33] ? 34'(-prod) : prod;
    prod_rnd   = prod_mag + 34'd32768;
    round_cell = prod[33] ? -$signed(prod_rnd[16+CW-1:16]) : $signed(prod_rnd[16+CW-1:16]);
  end

  logic signed [CW-1:0] hx, hy, sx, sy;

  always_ff @(posedge clk) begin
    if (prod_valid) begin
      case (prod_idx)
        ogru_pkg::CONV_HIT_X:    hx <= round_cell;
        ogru_pkg::CONV_HIT_Y:    hy <= round_cell;
        ogru_pkg::CONV_SENSOR_X: sx <= round_cell;
        default:                 sy <= round_cell;
      endcase
    end
  end

  function automatic logic in_map(input logic signed [CW-1:0] px,
                                  input logic signed [CW-1:0] py);
    in_map = !px[CW-1] && (px < CW'(MAP_WIDTH)) && !py[CW-1] && (py < CW'(MAP_HEIGHT));
  endfunction

  function automatic logic [AW-1:0] lin(input logic signed [CW-1:0] px,
                                        input logic signed [CW-1:0] py);
    logic [31:0] r;
    r   = 32'($unsigned(py)) * 32'(MAP_WIDTH) + 32'($unsigned(px));
    lin = r[AW-1:0];
  endfunction

  // Line ordering: pick the major axis and walk in increasing order.
  logic signed [DW-1:0] ddx, ddy;
  logic [DW-1:0]        adx, ady;
  logic                 steep_c, swap_c;
  logic signed [CW-1:0] a0, b0, a1, b1;
  logic                 steep;
  logic signed [CW-1:0] xs, ys, xe, ye;

  always_comb begin
    ddx     = DW'(hx) - DW'(sx);
    ddy     = DW'(hy) - DW'(sy);
    adx     = ddx[DW-1] ? DW'(-ddx) : DW'(ddx);
    ady     = ddy[DW-1] ? DW'(-ddy) : DW'(ddy);
    steep_c = ady > adx;
    a0      = steep_c ? sy : sx;
    b0      = steep_c ? sx : sy;
    a1      = steep_c ? hy : hx;
    b1      = steep_c ? hx : hy;
    swap_c  = a0 > a1;
  end

  always_ff @(posedge clk) begin
    if (cmd.order_en) begin
      steep <= steep_c;
      xs    <= swap_c ? a1 : a0;
      ys    <= swap_c ? b1 : b0;
      xe    <= swap_c ? a0 : a1;
      ye    <= swap_c ? b0 : b1;
    end
  end

  // Walker registers.
  logic signed [DW-1:0] dx, dy, dys;
  logic                 ystep_up;
  logic signed [EW-1:0] err, err_sum;
  logic signed [CW-1:0] wx, wy, px, py;
  logic                 step_y, is_hit, issue;
  logic [ogru_pkg::COUNT_W-1:0] count;
  logic                 pend_valid;
  logic [AW-1:0]        pend_addr;

  always_comb begin
    dys     = DW'(ye) - DW'(ys);
    px      = steep ? wy : wx;
    py      = steep ? wx : wy;
    err_sum = err + EW'(dy);
    step_y  = (EW'(err_sum) <<< 1) >= EW'(dx);
    is_hit  = (px == hx) && (py == hy);
    issue   = cmd.walk_en && !is_hit && in_map(px, py);
  end

  assign stat.walk_last = (wx == xe);

  always_ff @(posedge clk) begin
    if (cmd.prep_en) begin
      dx       <= DW'(xe) - DW'(xs);
      dy       <= dys[DW-1] ? DW'(-dys) : dys;
      ystep_up <= ys < ye;
      err      <= '0;
      wx       <= xs;
      wy       <= ys;
      count    <= '0;
    end else if (cmd.walk_en) begin
      wx <= wx + CW'(1);
      if (step_y) begin
        wy  <= ystep_up ? wy + CW'(1) : wy - CW'(1);
        err <= err_sum - EW'(dx);
      end else begin
        err <= err_sum;
      end
      if (issue && count != ogru_pkg::COUNT_MAX) count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) pend_valid <= 1'b0;
    else     pend_valid <= issue;
    pend_addr <= lin(px, py);
  end

  // Score memory with clearing pass after reset.
  logic [SW-1:0] mem [CELLS];
  logic [SW-1:0] rdata;
  logic [AW-1:0] clr_addr, wa, ra;
  logic [SW-1:0] wd;
  logic          we, re;
  logic          hit_in;
  logic [AW-1:0] hit_li;
  logic [7:0]    hit_sum;
  logic [SW-1:0] hit_new;

  always_ff @(posedge clk) begin
    if (rst)               clr_addr <= '0;
    else if (cmd.clear_en) clr_addr <= clr_addr + 1'b1;
  end
  assign stat.clear_last = (32'(clr_addr) == 32'(CELLS - 1));

  always_comb begin
    hit_in  = in_map(hx, hy);
    hit_li  = lin(hx, hy);
    hit_sum = {1'b0, rdata} + {1'b0, hit_step};
    hit_new = (hit_sum > 8'(ogru_pkg::SCORE_MAX)) ? ogru_pkg::SCORE_MAX : hit_sum[SW-1:0];

    we = 1'b0;
    wa = clr_addr;
    wd = ogru_pkg::SCORE_UNKNOWN;
    if (cmd.clear_en) begin
      we = 1'b1;
    end else if (pend_valid) begin
      we = 1'b1;
      wa = pend_addr;
      wd = (rdata > free_step) ? rdata - free_step : '0;
    end else if (cmd.hit_wr && hit_in) begin
      we = 1'b1;
      wa = hit_li;
      wd = hit_new;
    end

    re = cmd.read_issue || issue || cmd.hit_rd;
    if (cmd.read_issue)  ra = AW'(rd_cell);
    else if (cmd.hit_rd) ra = hit_li;
    else                 ra = lin(px, py);
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rdata <= mem[ra];
  end

  // Result and output registers.
  logic [15:0] res_addr;
  logic [7:0]  res_score;
  logic [9:0]  res_free;
  logic        res_oom;
  logic        rd_in_range;
  logic [31:0] hit_li32;

  assign rd_in_range = 32'(rd_cell) < 32'(CELLS);
  assign hit_li32    = 32'(hit_li);

  always_ff @(posedge clk) begin
    if (cmd.read_done) begin
      res_addr  <= rd_cell;
      res_free  <= '0;
      res_oom   <= !rd_in_range;
      res_score <= (!rd_in_range || rdata == ogru_pkg::SCORE_UNKNOWN)
                   ? ogru_pkg::SCORE_REPORT_UNKNOWN : {1'b0, rdata};
    end else if (cmd.hit_wr) begin
      res_free <= count;
      if (hit_in) begin
        res_addr  <= hit_li32[15:0];
        res_oom   <= 1'b0;
        res_score <= (hit_new == ogru_pkg::SCORE_UNKNOWN)
                     ? ogru_pkg::SCORE_REPORT_UNKNOWN : {1'b0, hit_new};
      end else begin
        res_addr  <= '0;
        res_oom   <= 1'b1;
        res_score <= '0;
      end
    end
  end

  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst)               out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready)    out_valid <= 1'b0;
    if (cmd.out_load) begin
      hit_address        <= res_addr;
      cell_score         <= res_score;
      free_cells_updated <= res_free;
      out_of_map         <= res_oom;
    end
  end

endmodule

[design/occupancy_grid_ray_update.sv]
// Top level of the occupancy grid ray update block.
`timescale 1ns / 1ps
// A read item reads one cell; an insert item walks every cell on its line (the larger
// of the cell distances in x and y, plus one) through the score memory.
// One item is in work at a time; a finished result waits in an output register.
// Reset is synchronous; afterwards a clearing pass writes 50 to every cell while no
// item is accepted.

module occupancy_grid_ray_update #(
  parameter int MAP_WIDTH  = 256,
  parameter int MAP_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port; the index follows the register list.
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // point_x_mm, point_y_mm, cell_address
  input  logic [0:0]  s_axis_tuser,  // opcode
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // hit_address, cell_score, free_cells_updated,
                                     // out_of_map, zero fill
);

  // The controller sequences conversion, line setup, the cell walk and the
  // hit cell update; the datapath holds all registers and the score memory.
  ogru_pkg::ogru_cmd_t    cmd;
  ogru_pkg::ogru_status_t stat;

  logic [15:0] hit_address;
  logic [7:0]  cell_score;
  logic [9:0]  free_cells_updated;
  logic        out_of_map;

  ogru_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_opcode (s_axis_tuser[0]),
    .in_ready  (s_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ogru_datapath #(
    .MAP_WIDTH  (MAP_WIDTH),
    .MAP_HEIGHT (MAP_HEIGHT)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_point_x_mm      (s_axis_tdata[15:0]),
    .in_point_y_mm      (s_axis_tdata[31:16]),
    .in_cell_address    (s_axis_tdata[47:32]),
    .out_ready          (m_axis_tready),
    .out_valid          (m_axis_tvalid),
    .hit_address        (hit_address),
    .cell_score         (cell_score),
    .free_cells_updated (free_cells_updated),
    .out_of_map         (out_of_map)
  );

  // Result item packed from the lowest bit up, filled to whole bytes.
  assign m_axis_tdata = {5'd0, out_of_map, free_cells_updated, cell_score, hit_address};

endmodule

[dv/occupancy_grid_ray_update_test.sv]
// Testbench for the occupancy grid ray update block: directed and random items, grid model.
`timescale 1ns / 1ps

module occupancy_grid_ray_update_test;

  // One expected result item, split into its fields.
  typedef struct {
    logic [15:0] hit_address;
    logic [7:0]  cell_score;
    logic [9:0]  free_cells;
    logic        out_of_map;
  } ray_result_t;

  // Register settings of one phase and the number of random items run under it.
  typedef struct {
    logic [15:0] org_x;
    logic [15:0] org_y;
    logic [15:0] scale;
    logic [6:0]  free_step;
    logic [6:0]  hit_step;
    int          items;
  } grid_setting_t;

  // Grid model: keeps its own copy of the scores and registers, predicts each result item
  // and compares the items coming out of the block in order.
  class grid_scoreboard;
    bit [6:0]           scores[65536];
    logic signed [15:0] org_x;
    logic signed [15:0] org_y;
    logic [15:0]        scale;
    logic [6:0]         free_step;
    logic [6:0]         hit_step;
    ray_result_t        pending[$];
    int                 errors;

    function new();
      foreach (scores[i]) scores[i] = ogru_pkg::SCORE_UNKNOWN;
      org_x = 16'sd0;
      org_y = -16'sd10000;
      scale = 16'd1638;
      free_step = 7'd1;
      hit_step = 7'd2;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        ogru_pkg::REG_ORIGIN_X:  org_x = val;
        ogru_pkg::REG_ORIGIN_Y:  org_y = val;
        ogru_pkg::REG_SCALE:     scale = val;
        ogru_pkg::REG_FREE_STEP: free_step = val[6:0];
        ogru_pkg::REG_HIT_STEP:  hit_step = val[6:0];
        default: ;
      endcase
    endfunction

    // Millimetres to a cell, rounding half away from zero.
    function longint mm_to_cell(logic signed [15:0] coord, logic signed [15:0] origin);
      longint prod;
      longint mag;
      prod = (longint'(coord) - longint'(origin)) * longint'({1'b0, scale});
      mag = (prod < 0) ? -prod : prod;
      mag = (mag + 32768) >>> 16;
      return (prod < 0) ? -mag : mag;
    endfunction

    function bit on_grid(longint cx, longint cy);
      return cx >= 0 && cx < 256 && cy >= 0 && cy < 256;
    endfunction

    function void note_item(logic op, logic signed [15:0] px_mm, logic signed [15:0] py_mm,
                            logic [15:0] addr);
      ray_result_t r;
      longint hx, hy, x0, y0, x1, y1, t, dx, dy, ystep, err, yy, xx, cx, cy;
      bit steep;
      int unsigned lowered;
      int unsigned s;
      if (op == ogru_pkg::OP_READ) begin
        // Every address is inside a 256 by 256 grid, so reads never fall off the map.
        r.hit_address = addr;
        r.cell_score = (scores[addr] == ogru_pkg::SCORE_UNKNOWN)
                       ? ogru_pkg::SCORE_REPORT_UNKNOWN : {1'b0, scores[addr]};
        r.free_cells = '0;
        r.out_of_map = 1'b0;
        pending = {pending, r};
        return;
      end
      hx = mm_to_cell(px_mm, org_x);
      hy = mm_to_cell(py_mm, org_y);
      x0 = mm_to_cell(16'sd0, org_x);
      y0 = mm_to_cell(16'sd0, org_y);
      x1 = hx;
      y1 = hy;
      lowered = 0;
      steep = ((y1 > y0) ? y1 - y0 : y0 - y1) > ((x1 > x0) ? x1 - x0 : x0 - x1);
      if (steep) begin
        t = x0; x0 = y0; y0 = t;
        t = x1; x1 = y1; y1 = t;
      end
      if (x0 > x1) begin
        t = x0; x0 = x1; x1 = t;
        t = y0; y0 = y1; y1 = t;
      end
      dx = x1 - x0;
      dy = (y1 > y0) ? y1 - y0 : y0 - y1;
      ystep = (y0 < y1) ? 1 : -1;
      err = 0;
      yy = y0;
      for (xx = x0; xx <= x1; xx++) begin
        cx = steep ? yy : xx;
        cy = steep ? xx : yy;
        err += dy;
        if (2 * err >= dx) begin
          yy += ystep;
          err -= dx;
        end
        // The hit cell itself is never lowered; free cells off the grid are skipped.
        if (!(cx == hx && cy == hy) && on_grid(cx, cy)) begin
          s = scores[cy * 256 + cx];
          scores[cy * 256 + cx] = 7'((s > free_step) ? s - free_step : 0);
          if (lowered < 1023) lowered++;
        end
      end
      if (on_grid(hx, hy)) begin
        s = scores[hy * 256 + hx] + hit_step;
        if (s > 100) s = 100;
        scores[hy * 256 + hx] = 7'(s);
        r.hit_address = 16'(hy * 256 + hx);
        r.cell_score = (s == ogru_pkg::SCORE_UNKNOWN) ? ogru_pkg::SCORE_REPORT_UNKNOWN
                                                      : 8'(s);
        r.out_of_map = 1'b0;
      end else begin
        r.hit_address = '0;
        r.cell_score = '0;
        r.out_of_map = 1'b1;
      end
      r.free_cells = 10'(lowered);
      pending = {pending, r};
    endfunction

    function void check_result(logic [39:0] data);
      ray_result_t r;
      if (pending.size() == 0) begin
        $error("result item 0x%h arrived with nothing expected", data);
        errors++;
        return;
      end
      r = pending.pop_front();
      if (data[15:0] !== r.hit_address) begin
        $error("hit_address: expected %0d, got %0d", r.hit_address, data[15:0]);
        errors++;
      end
      if (data[23:16] !== r.cell_score) begin
        $error("cell_score: expected %0d, got %0d", $signed(r.cell_score), $signed(data[23:16]));
        errors++;
      end
      if (data[33:24] !== r.free_cells) begin
        $error("free_cells_updated: expected %0d, got %0d", r.free_cells, data[33:24]);
        errors++;
      end
      if (data[34] !== r.out_of_map) begin
        $error("out_of_map: expected %0d, got %0d", r.out_of_map, data[34]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // point_x_mm, point_y_mm, cell_address
  logic [0:0]  s_axis_tuser = '0;  // opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;       // hit_address, cell_score, free_cells_updated, out_of_map

  grid_scoreboard grid_sb = new();
  bit             no_idle = 1'b0;  // when set, both sides run without gaps
  logic [15:0]    recent_hits[$];  // addresses worth reading back

  occupancy_grid_ray_update i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk = ~clk;

  function int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 5);
  endfunction

  // Present one item, hold it until the handshake, then idle for a drawn number of cycles.
  // The valid is only lowered when a gap follows, so back-to-back items keep it high.
  task send_item(logic op, logic [15:0] px, logic [15:0] py, logic [15:0] addr);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {addr, py, px};
    do @(posedge clk); while (!s_axis_tready);
    grid_sb.note_item(op, px, py, addr);
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task send_insert(logic [15:0] px, logic [15:0] py);
    send_item(ogru_pkg::OP_INSERT, px, py, 16'($urandom));
    if (grid_sb.pending[$].out_of_map == 1'b0)
      recent_hits = {recent_hits, grid_sb.pending[$].hit_address};
    if (recent_hits.size() > 32) void'(recent_hits.pop_front());
  endtask

  task send_read(logic [15:0] addr);
    send_item(ogru_pkg::OP_READ, 16'($urandom), 16'($urandom), addr);
  endtask

  // Drop the valid, then wait until every expected item is back and the block has settled.
  task drain();
    s_axis_tvalid <= 1'b0;
    while (grid_sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Writes all five registers on consecutive edges while the block is idle.
  task load_setting(grid_setting_t g);
    logic [15:0] vals[5];
    vals = '{g.org_x, g.org_y, g.scale, {9'd0, g.free_step}, {9'd0, g.hit_step}};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      grid_sb.set_reg(3'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Random part of one phase: mostly inserts, most of them near the map, reads of recently
  // hit cells, and some points and addresses drawn over the full range.
  task run_random(int count);
    int sel;
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 45)
        send_insert(16'($signed($urandom_range(0, 12000)) - 6000),
                    16'($signed($urandom_range(0, 12000)) - 6000));
      else if (sel < 60)
        send_insert(16'($urandom), 16'($urandom));
      else if (sel < 85 && recent_hits.size() != 0)
        send_read(recent_hits[$urandom_range(0, recent_hits.size() - 1)]);
      else
        send_read(16'($urandom));
    end
    no_idle = 1'b0;
  endtask

  // Receiver: random stalls between items, checked at each accepted result.
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      grid_sb.check_result(m_axis_tdata);
      stall = draw_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    grid_setting_t settings[5];
    settings[0] = '{16'h8000, 16'h7FFF, 16'd1,     7'd100, 7'd100, 60};
    settings[1] = '{16'd1000, -16'sd2000, 16'd3000, 7'd127, 7'd127, 250};
    settings[2] = '{16'd0,    16'd0,    16'd0,     7'd0,   7'd0,   40};
    settings[3] = '{16'h7FFF, 16'h8000, 16'd65535, 7'd5,   7'd7,   8};
    settings[4] = '{-16'sd5000, -16'sd5000, 16'd4000, 7'd3, 7'd9,   300};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed items under the reset settings. Sensor cell lands at column 0, row 250.
    send_insert(16'd0, 16'd0);              // sensor and hit share a cell
    send_insert(16'd0, 16'd5000);           // straight line up column 0
    send_insert(16'sd4000, 16'sd0);         // shallow line
    send_insert(16'sd3000, 16'sd1000);      // diagonal-ish line
    send_insert(16'h7FFF, 16'h7FFF);        // hit far off the map
    send_insert(16'h8000, 16'h8000);
    send_insert(16'h7FFF, 16'h8000);
    send_insert(16'h8000, 16'h7FFF);
    send_insert(-16'sd40, 16'd0);           // hit just left of the map
    send_read(16'd0);
    send_read(16'hFFFF);
    send_read(16'd250 * 16'd256);           // sensor cell, lowered by earlier lines
    for (int i = 0; i < 6; i++) send_insert(16'sd4000, 16'sd0);
    send_read(recent_hits[$]);
    send_read(16'd1234);                    // untouched cell reads as unknown
    run_random(300);

    // Every other phase starts from an idle block with all registers rewritten.
    foreach (settings[p]) begin
      drain();
      load_setting(settings[p]);
      if (p == 0) for (int i = 0; i < 3; i++) send_insert(16'h7FFF, 16'h7FFF);
      if (p == 1) for (int i = 0; i < 2; i++) send_insert(16'sd500, 16'sd0);
      run_random(settings[p].items);
    end

    drain();
    if (grid_sb.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #40000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
